[src/bvg_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// bvg_pkg
// Shared types and constants of the battery voltage guard: register indices,
// configuration bundle, reset values and timer control.
// ============================================================================
package bvg_pkg;

   localparam int unsigned MV_W       = 16;
   localparam int unsigned MS_W       = 32;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // Register indices of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MONITOR_ENABLE   = 3'd0,
      CSR_WARN_MV          = 3'd1,
      CSR_CLEAR_MV         = 3'd2,
      CSR_CRITICAL_MV      = 3'd3,
      CSR_RECOVER_MV       = 3'd4,
      CSR_CRITICAL_HOLD_MS = 3'd5,
      CSR_RECOVER_HOLD_MS  = 3'd6
   } csr_index_type;

   // Reset values of the configuration registers
   localparam logic            RST_MONITOR_ENABLE   = 1'b1;
   localparam logic [MV_W-1:0] RST_WARN_MV          = 16'd22000;
   localparam logic [MV_W-1:0] RST_CLEAR_MV         = 16'd22500;
   localparam logic [MV_W-1:0] RST_CRITICAL_MV      = 16'd20000;
   localparam logic [MV_W-1:0] RST_RECOVER_MV       = 16'd22000;
   localparam logic [MS_W-1:0] RST_CRITICAL_HOLD_MS = 32'd1000;
   localparam logic [MS_W-1:0] RST_RECOVER_HOLD_MS  = 32'd2000;

   typedef struct packed {
      logic            monitor_enable;
      logic [MV_W-1:0] warn_mv;
      logic [MV_W-1:0] clear_mv;
      logic [MV_W-1:0] critical_mv;
      logic [MV_W-1:0] recover_mv;
      logic [MS_W-1:0] critical_hold_ms;
      logic [MS_W-1:0] recover_hold_ms;
   } cfg_type;

   // Control of one debounce timer for one sample
   typedef struct packed {
      logic step;     // a sample moves through the datapath this cycle
      logic active;   // the latch side that this timer serves is selected
      logic qualify;  // valid sample on the far side of the threshold
   } dbc_ctl_type;

endpackage

[src/battery_voltage_guard.sv]
`timescale 1ns / 1ps
// ============================================================================
// battery_voltage_guard
// Debounced battery under-voltage guard with warning hysteresis.
// ============================================================================
// Usage:
//   req_*  : one sample per transfer (voltage, valid flag, latch state, time).
//   rsp_*  : one result per sample (warning flag, latch and clear requests).
//   csr_*  : register writes, taken in every cycle; write only while idle.
// Flow: an accepted sample is registered in the input stage, then
//   evaluated against the state and registered in the result stage once
//   that stage is free or being emptied, which raises rsp_valid.
// Throughput: one sample per cycle while rsp_ready is high. The compares and
//   the 32-bit elapsed-time subtraction sit in a single stage between the
//   input and result registers, and the state updates as a sample advances.
// Stall: while rsp_ready is low the result holds; one further sample waits in
//   the input stage, after which req_ready drops.
// Reset: both stages empty, warning flag and timers cleared, registers at
//   their documented defaults.
// ============================================================================
module battery_voltage_guard (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bvg_pkg::MV_W-1:0]       req_voltage_mv,
   input  logic                           req_sample_valid,
   input  logic                           req_critical_held,
   input  logic [bvg_pkg::MS_W-1:0]       req_now_ms,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_warn_on,
   output logic                           rsp_crit_set,
   output logic                           rsp_crit_release,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bvg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bvg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bvg_pkg::*;

   cfg_type         cfg;

   logic            in_valid_ff,   in_valid_in;
   logic [MV_W-1:0] in_voltage_ff;
   logic            in_sample_ff;
   logic            in_held_ff;
   logic [MS_W-1:0] in_now_ff;

   logic            warn_ff,       warn_in;
   logic            rsp_valid_ff,  rsp_valid_in;
   logic            rsp_warn_ff;
   logic            rsp_latch_ff;
   logic            rsp_clear_ff;

   logic            req_take;
   logic            advance;
   dbc_ctl_type     crit_ctl;
   dbc_ctl_type     recov_ctl;
   logic            crit_fire,     crit_pending;
   logic            recov_fire,    recov_pending;

   // Configuration registers
   bvg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Handshake: advance when the result stage is free or being emptied
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Warning hysteresis; the set test wins over the clear test
   always_comb begin
      warn_in = warn_ff;
      if (advance && cfg.monitor_enable && in_sample_ff) begin
         if (in_voltage_ff < cfg.warn_mv) begin
            warn_in = 1'b1;
         end else if (in_voltage_ff > cfg.clear_mv) begin
            warn_in = 1'b0;
         end
      end
   end

   // Timer control for each latch side
   always_comb begin
      crit_ctl.step     = advance;
      crit_ctl.active   = !in_held_ff;
      crit_ctl.qualify  = in_sample_ff && (in_voltage_ff < cfg.critical_mv);
      recov_ctl.step    = advance;
      recov_ctl.active  = in_held_ff;
      recov_ctl.qualify = in_sample_ff && (in_voltage_ff > cfg.recover_mv);
   end

   bvg_debounce u_crit (
      .clock   (clock),
      .reset   (reset),
      .ctl     (crit_ctl),
      .now_ms  (in_now_ff),
      .hold_ms (cfg.critical_hold_ms),
      .fire    (crit_fire),
      .pending (crit_pending)
   );

   bvg_debounce u_recov (
      .clock   (clock),
      .reset   (reset),
      .ctl     (recov_ctl),
      .now_ms  (in_now_ff),
      .hold_ms (cfg.recover_hold_ms),
      .fire    (recov_fire),
      .pending (recov_pending)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         warn_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         warn_ff      <= warn_in;
      end
   end

   // Capture the sample on a transfer
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_voltage_ff <= req_voltage_mv;
         in_sample_ff  <= req_sample_valid;
         in_held_ff    <= req_critical_held;
         in_now_ff     <= req_now_ms;
      end
   end

   // Load the result stage as the sample advances
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_warn_ff  <= warn_in;
         rsp_latch_ff <= crit_fire;
         rsp_clear_ff <= recov_fire;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_warn_on      = rsp_warn_ff;
   assign rsp_crit_set     = rsp_latch_ff;
   assign rsp_crit_release = rsp_clear_ff;

   // Only one side's request can fire for a sample
   a_one_request : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_latch_ff && rsp_clear_ff))
      else $error("latch and clear requested together");

   // The inactive side's timer is dropped after each sample
   a_side_cancel : assert property (@(posedge clock) disable iff (reset)
      advance |=> !(crit_pending && recov_pending))
      else $error("both debounce timers pending");

   // A held result is never overwritten
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      !(advance && rsp_valid_ff && !rsp_ready))
      else $error("result stage overwritten while stalled");

   // Both stages come out of reset empty
   a_reset_empty : assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !in_valid_ff))
      else $error("pipeline not empty after reset");

endmodule

[src/bvg_csr.sv]
`timescale 1ns / 1ps
// ============================================================================
// bvg_csr
// Configuration register file: thresholds, hold times and the monitor enable.
// ============================================================================
module bvg_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bvg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bvg_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output bvg_pkg::cfg_type                cfg
);
   import bvg_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Take a write in every cycle
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the index; unknown indices leave everything as it is
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_MONITOR_ENABLE:   cfg_in.monitor_enable   = csr_wdata[0];
            CSR_WARN_MV:          cfg_in.warn_mv          = csr_wdata[MV_W-1:0];
            CSR_CLEAR_MV:         cfg_in.clear_mv         = csr_wdata[MV_W-1:0];
            CSR_CRITICAL_MV:      cfg_in.critical_mv      = csr_wdata[MV_W-1:0];
            CSR_RECOVER_MV:       cfg_in.recover_mv       = csr_wdata[MV_W-1:0];
            CSR_CRITICAL_HOLD_MS: cfg_in.critical_hold_ms = csr_wdata[MS_W-1:0];
            CSR_RECOVER_HOLD_MS:  cfg_in.recover_hold_ms  = csr_wdata[MS_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.monitor_enable   <= RST_MONITOR_ENABLE;
         cfg_ff.warn_mv          <= RST_WARN_MV;
         cfg_ff.clear_mv         <= RST_CLEAR_MV;
         cfg_ff.critical_mv      <= RST_CRITICAL_MV;
         cfg_ff.recover_mv       <= RST_RECOVER_MV;
         cfg_ff.critical_hold_ms <= RST_CRITICAL_HOLD_MS;
         cfg_ff.recover_hold_ms  <= RST_RECOVER_HOLD_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[src/bvg_debounce.sv]
`timescale 1ns / 1ps
// ============================================================================
// bvg_debounce
// One debounce timer: the first qualifying sample records its timestamp, a
// later consecutive one fires once the wrapping elapsed time reaches the hold.
// ============================================================================
module bvg_debounce (
   input  logic                       clock,
   input  logic                       reset,
   input  bvg_pkg::dbc_ctl_type       ctl,
   input  logic [bvg_pkg::MS_W-1:0]   now_ms,
   input  logic [bvg_pkg::MS_W-1:0]   hold_ms,
   output logic                       fire,
   output logic                       pending
);
   import bvg_pkg::*;

   logic            pending_ff;
   logic            pending_in;
   logic [MS_W-1:0] start_ff;
   logic [MS_W-1:0] start_in;
   logic [MS_W-1:0] elapsed;
   logic            run;

   // Elapsed time wraps modulo 2^32
   assign elapsed = now_ms - start_ff;
   assign run     = ctl.active && ctl.qualify;
   assign fire    = run && pending_ff && (elapsed >= hold_ms);
   assign pending = pending_ff;

   // Start, hold or drop the timer
   always_comb begin
      pending_in = pending_ff;
      start_in   = start_ff;
      if (ctl.step) begin
         if (!run) begin
            pending_in = 1'b0;
         end else if (!pending_ff) begin
            pending_in = 1'b1;
            start_in   = now_ms;
         end else if (fire) begin
            pending_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
   end

endmodule
